/* rtl/rtc_calendar_counter_defines.svh */
// Assertion macros used by the checker file.
`ifndef RTC_CALENDAR_COUNTER_DEFINES_SVH
`define RTC_CALENDAR_COUNTER_DEFINES_SVH

// Overlapping implication, sampled on the rising edge, off during reset.
`define RTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rtc_cal_pkg.sv */
package rtc_cal_pkg;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    localparam logic [15:0] RESET_YEAR  = 16'd2016;
    localparam logic [23:0] RESET_TPS   = 24'd1000;
    localparam logic [15:0] INV25       = 16'd23593;   // 25 * 23593 == 1 mod 2^16
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;    // floor(65535 / 25)

    // Divisibility by 25 through the modular inverse: y*inv mod 2^16 <= limit.
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        logic        div4;
        logic        div16;
        prod  = {16'd0, y} * {16'd0, INV25};
        div25 = (prod[15:0] <= DIV25_LIMIT);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        if (div4 && div25)
            return div16;
        return div4;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/rtc_calendar_counter.sv */
// Calendar clock with a sub-second tick accumulator. One request is taken every clock
// cycle unless the output is stalled; its result passes through the request register
// and is registered again in the result register. Each request's update to
// accumulator, date, time and uptime is formed combinationally from the registered
// request and the current state. An add request counts at most one second; surplus
// ticks stay pending.
// ticks_per_second may be written only while no request is in flight.
module rtc_calendar_counter
    import rtc_cal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] tick_count,
    input  logic [15:0] set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    input  logic [23:0] set_ticks,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [31:0] subsecond,
    output logic [31:0] uptime_seconds,
    output logic        accepted
);

    logic [23:0] tps_reg;

    // request register
    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_op_reg;
    logic [15:0] s1_tick_reg;
    logic [15:0] s1_year_reg;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;
    logic [4:0]  s1_hour_reg;
    logic [5:0]  s1_minute_reg;
    logic [5:0]  s1_second_reg;
    logic [23:0] s1_ticks_reg;
    logic        s1_leap_reg;

    // calendar state
    logic [15:0] cur_year_reg, cur_year_next;
    logic        cur_leap_reg, cur_leap_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;      // one based
    logic [4:0]  cur_hour_reg, cur_hour_next;
    logic [5:0]  cur_minute_reg, cur_minute_next;
    logic [5:0]  cur_second_reg, cur_second_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] uptime_reg, uptime_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_minute_reg;
    logic [5:0]  out_second_reg;
    logic [31:0] out_subsecond_reg;
    logic [31:0] out_uptime_reg;
    logic        out_accepted_reg;

    logic        advance;
    logic        s1_load;
    logic        accepted_c;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;
    logic [32:0] diff_wide;
    logic        set_ok;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next  = s1_load ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // accumulator: saturating add, then try to take one period out
    assign sum_wide  = {1'b0, accum_reg} + {17'd0, s1_tick_reg};
    assign sum_sat   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    assign diff_wide = {1'b0, sum_sat} - {9'd0, tps_reg};

    assign set_ok = (s1_month_reg < 4'd12) && (s1_day_reg != 5'd0) &&
                    (s1_day_reg <= days_in(s1_month_reg, s1_leap_reg)) &&
                    (s1_hour_reg < 5'd24) && (s1_minute_reg < 6'd60) &&
                    (s1_second_reg < 6'd60) && (s1_ticks_reg < tps_reg);

    always_comb
    begin
        cur_year_next   = cur_year_reg;
        cur_leap_next   = cur_leap_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        cur_hour_next   = cur_hour_reg;
        cur_minute_next = cur_minute_reg;
        cur_second_next = cur_second_reg;
        accum_next      = accum_reg;
        uptime_next     = uptime_reg;
        accepted_c      = 1'b1;

        if (advance)
        begin
            case (s1_op_reg)
                OP_ADD:
                begin
                    accum_next = sum_sat;
                    if (!diff_wide[32])
                    begin
                        accum_next  = diff_wide[31:0];
                        uptime_next = uptime_reg + 32'd1;
                        // carry one second up through the calendar
                        if (cur_second_reg != 6'd59)
                            cur_second_next = cur_second_reg + 6'd1;
                        else
                        begin
                            cur_second_next = 6'd0;
                            if (cur_minute_reg != 6'd59)
                                cur_minute_next = cur_minute_reg + 6'd1;
                            else
                            begin
                                cur_minute_next = 6'd0;
                                if (cur_hour_reg != 5'd23)
                                    cur_hour_next = cur_hour_reg + 5'd1;
                                else
                                begin
                                    cur_hour_next = 5'd0;
                                    if (cur_day_reg != days_in(cur_month_reg, cur_leap_reg))
                                        cur_day_next = cur_day_reg + 5'd1;
                                    else
                                    begin
                                        cur_day_next = 5'd1;
                                        if (cur_month_reg != 4'd11)
                                            cur_month_next = cur_month_reg + 4'd1;
                                        else
                                        begin
                                            cur_month_next = 4'd0;
                                            cur_year_next  = cur_year_reg + 16'd1;
                                            cur_leap_next  = is_leap(cur_year_reg + 16'd1);
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                OP_SET:
                begin
                    if (set_ok)
                    begin
                        cur_year_next   = s1_year_reg;
                        cur_leap_next   = s1_leap_reg;
                        cur_month_next  = s1_month_reg;
                        cur_day_next    = s1_day_reg;
                        cur_hour_next   = s1_hour_reg;
                        cur_minute_next = s1_minute_reg;
                        cur_second_next = s1_second_reg;
                        accum_next      = {8'd0, s1_ticks_reg};
                    end
                    else
                        accepted_c = 1'b0;
                end
                default:
                begin
                    // read only, spare code behaves the same
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= RESET_TPS;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_year_reg   <= RESET_YEAR;
            cur_leap_reg   <= 1'b1;
            cur_month_reg  <= 4'd0;
            cur_day_reg    <= 5'd1;
            cur_hour_reg   <= 5'd0;
            cur_minute_reg <= 6'd0;
            cur_second_reg <= 6'd0;
            accum_reg      <= 32'd0;
            uptime_reg     <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
                tps_reg <= cfg_wr_data;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_year_reg   <= cur_year_next;
            cur_leap_reg   <= cur_leap_next;
            cur_month_reg  <= cur_month_next;
            cur_day_reg    <= cur_day_next;
            cur_hour_reg   <= cur_hour_next;
            cur_minute_reg <= cur_minute_next;
            cur_second_reg <= cur_second_next;
            accum_reg      <= accum_next;
            uptime_reg     <= uptime_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg     <= op_t'(operation);
            s1_tick_reg   <= tick_count;
            s1_year_reg   <= set_year;
            s1_month_reg  <= set_month;
            s1_day_reg    <= set_day;
            s1_hour_reg   <= set_hour;
            s1_minute_reg <= set_minute;
            s1_second_reg <= set_second;
            s1_ticks_reg  <= set_ticks;
            s1_leap_reg   <= is_leap(set_year);
        end
        if (advance)
        begin
            out_year_reg      <= cur_year_next;
            out_month_reg     <= cur_month_next;
            out_day_reg       <= cur_day_next;
            out_hour_reg      <= cur_hour_next;
            out_minute_reg    <= cur_minute_next;
            out_second_reg    <= cur_second_next;
            out_subsecond_reg <= accum_next;
            out_uptime_reg    <= uptime_next;
            out_accepted_reg  <= accepted_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign year           = out_year_reg;
    assign month          = out_month_reg;
    assign day            = out_day_reg;
    assign hour           = out_hour_reg;
    assign minute         = out_minute_reg;
    assign second         = out_second_reg;
    assign subsecond      = out_subsecond_reg;
    assign uptime_seconds = out_uptime_reg;
    assign accepted       = out_accepted_reg;

endmodule

/* rtl/rtc_cal_checker.sv */
`include "rtc_calendar_counter_defines.svh"

module rtc_cal_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [23:0] cfg_wr_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  operation,
    input logic [15:0] tick_count,
    input logic [15:0] set_year,
    input logic [3:0]  set_month,
    input logic [4:0]  set_day,
    input logic [4:0]  set_hour,
    input logic [5:0]  set_minute,
    input logic [5:0]  set_second,
    input logic [23:0] set_ticks,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [31:0] subsecond,
    input logic [31:0] uptime_seconds,
    input logic        accepted
);

    // a stalled result stays valid and keeps its uptime and subsecond
    `RTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(uptime_seconds) && $stable(subsecond), "stalled result changed")

    `RTC_ASSERT_IMP(a_cal_range, out_valid, (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) && (month < 4'd12) && (day != 5'd0), "calendar field out of range")

    // back-to-back results are consecutive requests: uptime moves by at most one
    `RTC_ASSERT_IMP(a_uptime_step, (out_valid && !out_stall) ##1 out_valid, (uptime_seconds == $past(uptime_seconds)) || (uptime_seconds == $past(uptime_seconds) + 32'd1), "uptime jumped")

    // a rejected set leaves the calendar as the previous result showed it
    `RTC_ASSERT_IMP(a_reject_keeps, (out_valid && !out_stall) ##1 (out_valid && !accepted), $stable(year) && $stable(day) && $stable(second) && $stable(subsecond) && $stable(uptime_seconds), "rejected set changed state")

endmodule

bind rtc_calendar_counter rtc_cal_checker u_rtc_cal_checker (.*);
